// ===== rtl/pooled_linked_list_manager_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Pooled linked list manager: assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef POOLED_LINKED_LIST_MANAGER_UNIT_DEFINES_SVH
`define POOLED_LINKED_LIST_MANAGER_UNIT_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent.
`define PLLM_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define PLLM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/pllm_pkg.sv =====
// ----------------------------------------------------------------------------
// Pooled linked list manager package
// Field widths, opcodes and status codes shared by the block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pllm_pkg;

    localparam int OPCODE_W     = 2;
    localparam int DATA_W       = 16;
    localparam int STATUS_W     = 2;
    localparam int SLOT_FIELD_W = 4;

    typedef enum logic [OPCODE_W-1:0] {
        OP_APPEND = 2'd0,
        OP_INSERT = 2'd1,
        OP_REMOVE = 2'd2
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2,
        ST_EMPTY     = 2'd3
    } t_status;

endpackage

// ===== rtl/pllm_if.sv =====
// ----------------------------------------------------------------------------
// Pooled linked list manager channels
// Request and response valid/ready channels with their payloads.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pllm_req_if import pllm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [OPCODE_W-1:0]        opcode;
    logic signed [DATA_W-1:0]   value;
    logic signed [DATA_W-1:0]   key;

    modport source (output valid, opcode, value, key, input ready);
    modport sink   (input valid, opcode, value, key, output ready);
endinterface

interface pllm_rsp_if import pllm_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [SLOT_FIELD_W-1:0]    slot;

    modport source (output valid, status, slot, input ready);
    modport sink   (input valid, status, slot, output ready);
endinterface

// ===== rtl/pooled_linked_list_manager_unit.sv =====
// ----------------------------------------------------------------------------
// Pooled linked list manager (top level)
// Each accepted request walks the list as needed, updates the slot RAMs
// and then loads the response into the output register in S_RESP.
// One request at a time; ready again the cycle after the response
// is registered. Reset (sync, active low) empties the list and then
// rebuilds the free chain in a clearing pass; not ready meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pooled_linked_list_manager_unit_defines.svh"

module pooled_linked_list_manager_unit import pllm_pkg::*; #(
    parameter int POOL_SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    pllm_req_if.sink    i_req,
    pllm_rsp_if.source  o_rsp
);

    // Slot index width, and link width: a link also codes "null" as the
    // value POOL_SLOTS, one past the last slot.
    localparam int SW = $clog2(POOL_SLOTS);
    localparam int LW = $clog2(POOL_SLOTS + 1);
    localparam logic [LW-1:0] LINK_NULL = LW'(POOL_SLOTS);
    localparam logic [SW-1:0] LAST_SLOT = SW'(POOL_SLOTS - 1);

    // Sequencer states.
    //   S_CLEAR    rebuild free chain after reset, one slot per cycle
    //   S_IDLE     wait for a request; the head (or free head) read is issued
    //   S_WALK_CHK compare one list entry per cycle, next read issued from
    //              the link that just came back
    //   S_TAKE_WR  pop the free head: new value and link written
    //   S_LINK_WR  hook the new slot behind the tail / matched entry
    //   S_UNLINK   bypass the removed entry (or move the list head)
    //   S_FREE_WR  push the removed slot onto the free list
    //   S_RESP     hand the result to the output register
    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_WALK_CHK,
        S_TAKE_WR,
        S_LINK_WR,
        S_UNLINK,
        S_FREE_WR,
        S_RESP
    } t_state;

    t_state             r_state;
    logic [SW-1:0]      r_clr;       // clearing pass pointer
    logic [LW-1:0]      r_head;      // data list head
    logic [LW-1:0]      r_free;      // free list head
    t_opcode            r_op;
    logic [DATA_W-1:0]  r_val;       // value to store
    logic [DATA_W-1:0]  r_tgt;       // value searched for (key or value)
    logic [SW-1:0]      r_cur;       // entry under the walk / tail / match
    logic [LW-1:0]      r_prev;      // entry before r_cur, null at the head
    logic [LW-1:0]      r_cur_link;  // link of the matched entry
    logic [SW-1:0]      r_new;       // slot popped from the free list
    t_status            r_status;
    logic [SW-1:0]      r_slot;

    // Output register, holds until the consumer takes it.
    logic                    r_rsp_valid;
    t_status                 r_rsp_status;
    logic [SLOT_FIELD_W-1:0] r_rsp_slot;

    // RAM ports.
    logic [SW-1:0]     w_rd_addr;
    logic [DATA_W-1:0] w_val_rd;
    logic [LW-1:0]     w_link_rd;
    logic              w_val_we;
    logic              w_link_we;
    logic [SW-1:0]     w_link_waddr;
    logic [LW-1:0]     w_link_wdata;

    logic w_head_live;
    logic w_free_live;
    logic w_link_live;
    logic w_hit;
    logic w_advance;
    logic w_accept;
    logic w_rsp_free;

    assign w_head_live = (r_head < LINK_NULL);
    assign w_free_live = (r_free < LINK_NULL);
    assign w_link_live = (w_link_rd < LINK_NULL);

    // The one shared comparator: entry value against the search target.
    assign w_hit = (w_val_rd == r_tgt);

    // Keep walking: append runs to the tail, the others stop at a match.
    assign w_advance = w_link_live && ((r_op == OP_APPEND) || !w_hit);

    assign w_accept   = i_req.valid && i_req.ready;
    assign w_rsp_free = !r_rsp_valid || o_rsp.ready;

    // Read address. In idle the head is read ahead (or the free head when
    // the list is empty, which is what an insert into it needs). During the
    // walk the link just read goes straight back as the next address; once
    // the walk stops the free head is read for a possible pop.
    always_comb begin
        case (r_state)
            S_IDLE:     w_rd_addr = w_head_live ? r_head[SW-1:0] : r_free[SW-1:0];
            S_WALK_CHK: w_rd_addr = w_advance ? w_link_rd[SW-1:0] : r_free[SW-1:0];
            default:    w_rd_addr = r_free[SW-1:0];
        endcase
    end

    // Link RAM write port, shared by every link update.
    always_comb begin
        w_link_we    = 1'b0;
        w_link_waddr = r_cur;
        w_link_wdata = r_free;
        case (r_state)
            S_CLEAR: begin
                // slot i -> i+1; the last one lands on the null code
                w_link_we    = 1'b1;
                w_link_waddr = r_clr;
                w_link_wdata = LW'(r_clr) + LW'(1);
            end
            S_TAKE_WR: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_free[SW-1:0];
                w_link_wdata = r_cur_link;
            end
            S_LINK_WR: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_cur;
                w_link_wdata = LW'(r_new);
            end
            S_UNLINK: begin
                w_link_we    = (r_prev != LINK_NULL);
                w_link_waddr = r_prev[SW-1:0];
                w_link_wdata = r_cur_link;
            end
            S_FREE_WR: begin
                w_link_we    = 1'b1;
                w_link_waddr = r_cur;
                w_link_wdata = r_free;
            end
            default: begin
                w_link_we = 1'b0;
            end
        endcase
    end

    assign w_val_we = (r_state == S_TAKE_WR);

    pllm_ram #(
        .DEPTH (POOL_SLOTS),
        .WIDTH (DATA_W)
    ) u_value_ram (
        .i_clk   (i_clk),
        .i_we    (w_val_we),
        .i_waddr (r_free[SW-1:0]),
        .i_wdata (r_val),
        .i_raddr (w_rd_addr),
        .o_rdata (w_val_rd)
    );

    pllm_ram #(
        .DEPTH (POOL_SLOTS),
        .WIDTH (LW)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (w_link_we),
        .i_waddr (w_link_waddr),
        .i_wdata (w_link_wdata),
        .i_raddr (w_rd_addr),
        .o_rdata (w_link_rd)
    );

    // Sequencer and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_head      <= LINK_NULL;
            r_free      <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            // taken response drops unless S_RESP loads the next one
            if (r_rsp_valid && o_rsp.ready && (r_state != S_RESP)) begin
                r_rsp_valid <= 1'b0;
            end

            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + SW'(1);
                    if (r_clr == LAST_SLOT) begin
                        r_state <= S_IDLE;
                    end
                end

                S_IDLE: begin
                    if (w_accept) begin
                        r_op       <= t_opcode'(i_req.opcode);
                        r_val      <= i_req.value;
                        r_tgt      <= (i_req.opcode == OP_INSERT) ? i_req.key : i_req.value;
                        r_cur      <= r_head[SW-1:0];
                        r_prev     <= LINK_NULL;
                        r_cur_link <= LINK_NULL;
                        r_status   <= ST_DONE;
                        r_slot     <= '0;
                        case (i_req.opcode)
                            OP_APPEND, OP_INSERT: begin
                                if (!w_free_live) begin
                                    r_status <= ST_FULL;
                                    r_state  <= S_RESP;
                                end else if (!w_head_live) begin
                                    // empty list: new entry becomes the head
                                    r_state <= S_TAKE_WR;
                                end else begin
                                    r_state <= S_WALK_CHK;
                                end
                            end
                            OP_REMOVE: begin
                                if (!w_head_live) begin
                                    r_status <= ST_EMPTY;
                                    r_state  <= S_RESP;
                                end else begin
                                    r_state <= S_WALK_CHK;
                                end
                            end
                            default: begin
                                // unused opcode: no change, done with slot 0
                                r_state <= S_RESP;
                            end
                        endcase
                    end
                end

                S_WALK_CHK: begin
                    if (w_advance) begin
                        r_prev <= LW'(r_cur);
                        r_cur  <= w_link_rd[SW-1:0];
                    end else if (r_op == OP_APPEND) begin
                        // tail reached, its link is null
                        r_cur_link <= w_link_rd;
                        r_state    <= S_TAKE_WR;
                    end else if (w_hit) begin
                        r_cur_link <= w_link_rd;
                        r_state    <= (r_op == OP_INSERT) ? S_TAKE_WR : S_UNLINK;
                    end else begin
                        // end of list without a match
                        r_status <= ST_NOT_FOUND;
                        r_state  <= S_RESP;
                    end
                end

                S_TAKE_WR: begin
                    // link RAM output holds the free head's link here
                    r_new  <= r_free[SW-1:0];
                    r_free <= w_link_rd;
                    if (!w_head_live) begin
                        r_head  <= r_free;
                        r_slot  <= r_free[SW-1:0];
                        r_state <= S_RESP;
                    end else begin
                        r_state <= S_LINK_WR;
                    end
                end

                S_LINK_WR: begin
                    r_slot  <= r_new;
                    r_state <= S_RESP;
                end

                S_UNLINK: begin
                    if (r_prev == LINK_NULL) begin
                        r_head <= r_cur_link;
                    end
                    r_state <= S_FREE_WR;
                end

                S_FREE_WR: begin
                    r_free  <= LW'(r_cur);
                    r_slot  <= r_cur;
                    r_state <= S_RESP;
                end

                S_RESP: begin
                    if (w_rsp_free) begin
                        r_rsp_valid  <= 1'b1;
                        r_rsp_status <= r_status;
                        r_rsp_slot   <= (r_status == ST_DONE) ?
                                        SLOT_FIELD_W'(r_slot) : '0;
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign i_req.ready  = (r_state == S_IDLE);
    assign o_rsp.valid  = r_rsp_valid;
    assign o_rsp.status = r_rsp_status;
    assign o_rsp.slot   = r_rsp_slot;

    // A request keeps the block busy: ready is low in the cycle after accept.
    `PLLM_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !i_req.ready, "ready high right after accept")
    // One slot can never sit at the head of both chains.
    `PLLM_ASSERT_SAME(a_heads_distinct, i_clk, i_rst_n, w_head_live && w_free_live, r_head != r_free, "list head equals free head")
    // Failed requests report slot zero.
    `PLLM_ASSERT_SAME(a_fail_slot_zero, i_clk, i_rst_n, o_rsp.valid && (o_rsp.status != ST_DONE), o_rsp.slot == '0, "nonzero slot on failed request")

endmodule

// ===== rtl/pllm_ram.sv =====
// ----------------------------------------------------------------------------
// Pooled linked list manager slot RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pllm_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== sim/tb_pooled_linked_list_manager_unit.sv =====
// ----------------------------------------------------------------------------
// Pooled linked list manager testbench
// Drives append, insert-after-key, remove and unused requests into the block.
// A tracker keeps its own copy of the slot pool, the data chain and the free
// chain, predicts status and slot for every accepted request, and checks each
// response in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_pooled_linked_list_manager_unit;
    import pllm_pkg::*;

    localparam int          POOL_SLOTS   = 16;
    localparam int          LINK_NULL    = POOL_SLOTS;   // link that names no slot
    localparam logic [1:0]  OP_UNUSED    = 2'd3;         // opcode with no effect
    localparam int          RANDOM_ITEMS = 700;
    localparam int          SEGMENT_LEN  = 100;
    localparam int          RUN_LIMIT_NS = 2_000_000;

    typedef struct packed {
        logic [STATUS_W-1:0]     status;
        logic [SLOT_FIELD_W-1:0] slot;
    } t_rsp_item;

    // ------------------------------------------------------------------------
    // Tracker: mirror of the slot pool plus the queue of pending responses.
    // ------------------------------------------------------------------------
    class list_pool_tracker;
        logic [DATA_W-1:0] entry_val [POOL_SLOTS];
        int                entry_link[POOL_SLOTS];
        int                head_slot;
        int                free_head;
        t_rsp_item         pending_rsp[$];
        int                mismatches;

        function new();
            for (int i = 0; i < POOL_SLOTS; i++) begin
                entry_val[i]  = '0;
                entry_link[i] = i + 1;
            end
            head_slot  = LINK_NULL;
            free_head  = 0;
            mismatches = 0;
        endfunction

        function bit is_slot(int s);
            return (s >= 0) && (s < POOL_SLOTS);
        endfunction

        function int take_free(logic [DATA_W-1:0] v);
            int s;
            s              = free_head;
            free_head      = entry_link[s];
            entry_val[s]   = v;
            entry_link[s]  = LINK_NULL;
            return s;
        endfunction

        function void give_free(int s);
            entry_link[s] = free_head;
            free_head     = s;
        endfunction

        function int live_count();
            int i;
            int n;
            i = head_slot;
            n = 0;
            while (is_slot(i) && n < POOL_SLOTS) begin
                n++;
                i = entry_link[i];
            end
            return n;
        endfunction

        // Value of a random entry on the data chain; random if the chain is empty.
        function logic [DATA_W-1:0] pick_live_value();
            int n;
            int i;
            int idx;
            n = live_count();
            if (n == 0) return DATA_W'($urandom);
            idx = $urandom_range(0, n - 1);
            i   = head_slot;
            repeat (idx) i = entry_link[i];
            return entry_val[i];
        endfunction

        // Apply one accepted request to the mirror and queue its response.
        function void note_request(logic [1:0] op, logic [DATA_W-1:0] v,
                                   logic [DATA_W-1:0] k);
            t_status   st;
            int        sl;
            int        i;
            int        s;
            int        steps;
            t_rsp_item r;
            st = ST_DONE;
            sl = 0;
            if (op == OP_APPEND || op == OP_INSERT) begin
                if (!is_slot(free_head)) begin
                    st = ST_FULL;
                end else if (!is_slot(head_slot)) begin
                    // empty list: either opcode makes the new slot the head
                    s         = take_free(v);
                    head_slot = s;
                    sl        = s;
                end else if (op == OP_APPEND) begin
                    i     = head_slot;
                    steps = 1;
                    while (is_slot(entry_link[i]) && steps < POOL_SLOTS) begin
                        i = entry_link[i];
                        steps++;
                    end
                    s             = take_free(v);
                    entry_link[i] = s;
                    sl            = s;
                end else begin
                    i     = head_slot;
                    steps = 0;
                    while (is_slot(i) && entry_val[i] != k && steps < POOL_SLOTS) begin
                        i = entry_link[i];
                        steps++;
                    end
                    if (!is_slot(i) || entry_val[i] != k) begin
                        st = ST_NOT_FOUND;
                    end else begin
                        s             = take_free(v);
                        entry_link[s] = entry_link[i];
                        entry_link[i] = s;
                        sl            = s;
                    end
                end
            end else if (op == OP_REMOVE) begin
                if (!is_slot(head_slot)) begin
                    st = ST_EMPTY;
                end else if (entry_val[head_slot] == v) begin
                    s         = head_slot;
                    head_slot = entry_link[s];
                    give_free(s);
                    sl        = s;
                end else begin
                    i     = head_slot;
                    steps = 1;
                    while (is_slot(entry_link[i]) && entry_val[entry_link[i]] != v &&
                           steps < POOL_SLOTS) begin
                        i = entry_link[i];
                        steps++;
                    end
                    s = entry_link[i];
                    if (!is_slot(s) || entry_val[s] != v) begin
                        st = ST_NOT_FOUND;
                    end else begin
                        entry_link[i] = entry_link[s];
                        give_free(s);
                        sl            = s;
                    end
                end
            end
            if (st != ST_DONE) sl = 0;
            r.status = st;
            r.slot   = SLOT_FIELD_W'(sl);
            pending_rsp.push_back(r);
        endfunction

        function void check_response(logic [STATUS_W-1:0] status,
                                     logic [SLOT_FIELD_W-1:0] slot);
            t_rsp_item r;
            if (pending_rsp.size() == 0) begin
                $display("%0t: response with none pending, status %0d slot %0d",
                         $time, status, slot);
                mismatches++;
                return;
            end
            r = pending_rsp.pop_front();
            if (status !== r.status) begin
                $display("%0t: status expected %0d actual %0d", $time, r.status, status);
                mismatches++;
            end
            if (slot !== r.slot) begin
                $display("%0t: slot expected %0d actual %0d", $time, r.slot, slot);
                mismatches++;
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, reset, channels and the block
    // ------------------------------------------------------------------------
    logic i_clk;
    logic i_rst_n;

    pllm_req_if req_if();
    pllm_rsp_if rsp_if();

    pooled_linked_list_manager_unit #(
        .POOL_SLOTS (POOL_SLOTS)
    ) u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    list_pool_tracker tracker = new();

    // 0: no idling at all, 1: light, 2: heavy. Shared by both channel sides.
    int          idle_mode;
    int unsigned ready_hold = 0;

    initial begin
        i_clk = 1'b0;
    end

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Mostly short gaps, now and then a long one.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (idle_mode == 0) return 0;
        r = $urandom_range(0, 99);
        if (r < ((idle_mode == 1) ? 70 : 40)) return 0;
        if (r < 93) return $urandom_range(1, 4);
        return $urandom_range(10, 30);
    endfunction

    // Values drawn from a small hot set collide often, which is what makes
    // key lookups and removals hit.
    function automatic logic [DATA_W-1:0] fresh_value();
        logic [DATA_W-1:0] hot[8];
        hot = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000,
                16'hFFFF, 16'h5555, 16'hAAAA, 16'h0100};
        if ($urandom_range(0, 9) < 5) return hot[$urandom_range(0, 7)];
        return DATA_W'($urandom);
    endfunction

    // ------------------------------------------------------------------------
    // Response side: random back-pressure, check every accepted response.
    // Sampling at the edge sees pre-edge values, so no ordering race.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        logic rdy;
        if (ready_hold > 0) begin
            ready_hold = ready_hold - 1;
            rdy        = 1'b0;
        end else begin
            rdy        = 1'b1;
            ready_hold = pick_gap();
        end
        rsp_if.ready <= rdy;
        if (i_rst_n && rsp_if.valid && rsp_if.ready)
            tracker.check_response(rsp_if.status, rsp_if.slot);
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    // Present one request and hold it until accepted. valid stays high into
    // the next call when that call has no gap.
    task automatic send_req(logic [1:0] op, logic [DATA_W-1:0] v, logic [DATA_W-1:0] k);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid  <= 1'b1;
        req_if.opcode <= op;
        req_if.value  <= v;
        req_if.key    <= k;
        do @(posedge i_clk); while (!req_if.ready);
        tracker.note_request(op, v, k);
    endtask

    // Hold off the sender until every pending response is back.
    task automatic wait_drained();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (tracker.pending_rsp.size() != 0) @(posedge i_clk);
    endtask

    // One random request; the opcode mix follows the phase so the list
    // swings between empty and full.
    task automatic send_random(int phase);
        int unsigned       r;
        int                n;
        logic [1:0]        op;
        logic [DATA_W-1:0] v;
        logic [DATA_W-1:0] k;
        int                p_app;
        int                p_ins;
        int                p_rem;
        n = tracker.live_count();
        case (phase)
            0: begin p_app = 50; p_ins = 30; p_rem = 15; end  // growing
            1: begin p_app = 35; p_ins = 25; p_rem = 35; end  // balanced
            default: begin p_app = 20; p_ins = 15; p_rem = 60; end  // draining
        endcase
        r = $urandom_range(0, 99);
        if (r < p_app)                     op = OP_APPEND;
        else if (r < p_app + p_ins)        op = OP_INSERT;
        else if (r < p_app + p_ins + p_rem) op = OP_REMOVE;
        else                               op = OP_UNUSED;
        v = fresh_value();
        k = fresh_value();
        // most removes and lookups target a value that is on the list
        if (n > 0 && $urandom_range(0, 99) < 75) begin
            if (op == OP_REMOVE) v = tracker.pick_live_value();
            else                 k = tracker.pick_live_value();
        end
        if (op == OP_UNUSED) begin
            v = DATA_W'($urandom);
            k = DATA_W'($urandom);
        end
        send_req(op, v, k);
    endtask

    initial begin
        req_if.valid  <= 1'b0;
        req_if.opcode <= OP_APPEND;
        req_if.value  <= '0;
        req_if.key    <= '0;
        idle_mode  = 1;
        i_rst_n    = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // -------- directed part --------
        send_req(OP_REMOVE, 16'h1234, 16'h0000);   // remove from empty list
        send_req(OP_UNUSED, 16'hFFFF, 16'hFFFF);   // unused opcode
        send_req(OP_INSERT, 16'h7FFF, 16'h0000);   // insert into empty list -> head
        send_req(OP_APPEND, 16'h8000, 16'h0000);
        send_req(OP_APPEND, 16'h0000, 16'h7FFF);
        send_req(OP_APPEND, 16'hFFFF, 16'h0000);
        send_req(OP_INSERT, 16'h1234, 16'h7FFF);   // insert after head
        send_req(OP_INSERT, 16'h4321, 16'h5A5A);   // key absent
        send_req(OP_REMOVE, 16'h0BAD, 16'h0000);   // value absent
        send_req(OP_REMOVE, 16'h7FFF, 16'h0000);   // remove head
        send_req(OP_REMOVE, 16'h8000, 16'h0000);   // remove middle
        send_req(OP_REMOVE, 16'hFFFF, 16'h0000);   // remove tail
        while (tracker.is_slot(tracker.free_head))
            send_req(OP_APPEND, fresh_value(), 16'h0000);
        send_req(OP_APPEND, 16'h2222, 16'h0000);   // pool full
        send_req(OP_INSERT, 16'h3333, 16'h8000);   // pool full on insert
        wait_drained();

        // -------- random part --------
        for (int seg = 0; seg * SEGMENT_LEN < RANDOM_ITEMS; seg++) begin
            idle_mode = (seg + 1) % 3;
            for (int j = 0; j < SEGMENT_LEN; j++) send_random(seg % 3);
            wait_drained();
        end

        // let the block settle for one worst-case walk before the verdict
        repeat (POOL_SLOTS + 8) @(posedge i_clk);
        if (tracker.mismatches == 0 && tracker.pending_rsp.size() == 0)
            $display("tb_pooled_linked_list_manager_unit OK");
        else
            $display("tb_pooled_linked_list_manager_unit NOT OK");
        $finish;
    end

    initial begin
        #RUN_LIMIT_NS;
        $display("tb_pooled_linked_list_manager_unit NOT OK");
        $finish;
    end

endmodule
